>>> hdl/tts_pkg.sv
// shared constants, types and helper functions for the tiled texture swizzle
`default_nettype none

package tts_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned POS_W   = $clog2(MAX_DIM);
  localparam int unsigned TSH_W   = $clog2(POS_W + 1);
  localparam int unsigned TILE_W  = 2 * POS_W;
  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned BCNT_W  = 3;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned TILE_LOG = 3;
  localparam int unsigned MORTON_W = 2 * TILE_LOG;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FORMAT = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FMT_RGBA  = 2'd0,
    FMT_RGB   = 2'd1,
    FMT_ALPHA = 2'd2,
    FMT_RSVD  = 2'd3
  } fmt_t;

  localparam logic [BCNT_W-1:0] BPP_RGBA  = 3'd4;
  localparam logic [BCNT_W-1:0] BPP_RGB   = 3'd3;
  localparam logic [BCNT_W-1:0] BPP_ALPHA = 3'd1;

  // decoded configuration as used by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [TSH_W-1:0]  tile_shift;
    logic [BCNT_W-1:0] bpp;
  } cfg_t;

  // one item held between the counter stage and the result stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // log2 of tiles per row: ceil(log2(w)) less TILE_LOG, never below zero
  function automatic logic [TSH_W-1:0] tile_shift_of(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] m;
    logic [TSH_W:0]   len;
    m   = w - DIM_W'(1);
    len = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if (m[i]) len = (TSH_W + 1)'(i + 1);
    end
    return (len > (TSH_W + 1)'(TILE_LOG)) ? TSH_W'(len - (TSH_W + 1)'(TILE_LOG)) : '0;
  endfunction

  function automatic logic [BCNT_W-1:0] bpp_of(input fmt_t f);
    logic [BCNT_W-1:0] r;
    unique case (f)
      FMT_RGB:   r = BPP_RGB;
      FMT_ALPHA: r = BPP_ALPHA;
      default:   r = BPP_RGBA;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tiled_texture_swizzle.sv
// top level of the tiled texture swizzle
// Source pixels enter on the in_ channel in raster order, one transfer per
// pixel, and leave on the out_ channel as one transfer each: the byte offset
// of the texel in the 8x8-tiled, Morton-ordered texture, the pixel bytes
// reversed over the format's byte count, that byte count and a flag on the
// final pixel of the image.
// Throughput is one pixel per clock while out_ready stays high. A pixel goes
// from the input transfer through the input register with the column and row
// counters, then the address and byte-order logic, into the result register.
// The cfg_ channel writes image width (0), image height (1) and pixel format
// (2); it is always ready and should only be used while no pixel is in flight.
// Width and height are clamped to 1..1024 on write.
// Reset (synchronous, active low) empties both stages, zeroes the counters and
// loads width 1024, height 1024 and four-byte RGBA.
// When the receiver stalls, the result register holds its transfer and the
// input register, if empty, still takes one more pixel before in_ready drops.
`default_nettype none

module tiled_texture_swizzle (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [tts_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [tts_pkg::DIM_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [tts_pkg::PIX_W-1:0]   in_pixel_data,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [tts_pkg::ADDR_W-1:0]  out_dest_byte_addr,
  output      logic [tts_pkg::PIX_W-1:0]   out_texel_data,
  output      logic [tts_pkg::BCNT_W-1:0]  out_byte_count,
  output      logic                        out_last_pixel
);
  import tts_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid, item_ready;

  tts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_data (in_pixel_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  tts_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .item               (item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dest_byte_addr (out_dest_byte_addr),
    .out_texel_data     (out_texel_data),
    .out_byte_count     (out_byte_count),
    .out_last_pixel     (out_last_pixel)
  );

endmodule

`default_nettype wire

>>> hdl/tts_cfg.sv
// configuration registers, stored already clamped and decoded
`default_nettype none

module tts_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [tts_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [tts_pkg::DIM_W-1:0]   cfg_wdata,
  output      tts_pkg::cfg_t               cfg
);
  import tts_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [DIM_W-1:0] dim;

  assign cfg_ready = 1'b1;
  assign dim       = clamp_dim(cfg_wdata);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH: begin
          cfg_nxt.width      = dim;
          cfg_nxt.tile_shift = tile_shift_of(dim);
        end
        CFG_HEIGHT: cfg_nxt.height = dim;
        CFG_FORMAT: cfg_nxt.bpp    = bpp_of(fmt_t'(cfg_wdata[1:0]));
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width      <= DIM_W'(MAX_DIM);
      cfg_r.height     <= DIM_W'(MAX_DIM);
      cfg_r.tile_shift <= tile_shift_of(DIM_W'(MAX_DIM));
      cfg_r.bpp        <= BPP_RGBA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/tts_front.sv
// input register with the column and row counters
`default_nettype none

module tts_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tts_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [tts_pkg::PIX_W-1:0]  in_pixel_data,
  output      logic                       item_valid,
  input  wire logic                       item_ready,
  output      tts_pkg::item_t             item
);
  import tts_pkg::*;

  logic             valid_r, valid_nxt;
  item_t            item_r, item_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, img_end, in_xfer;

  assign in_ready = !valid_r || item_ready;
  assign in_xfer  = in_valid && in_ready;

  assign col_inc = DIM_W'(col_r) + DIM_W'(1);
  assign row_inc = DIM_W'(row_r) + DIM_W'(1);
  // a counter left beyond a newly written limit also ends its row or image
  assign row_end = col_inc >= cfg.width;
  assign img_end = row_end && (row_inc >= cfg.height);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    item_nxt  = item_r;
    valid_nxt = valid_r;
    if (item_ready) valid_nxt = 1'b0;
    if (in_xfer) begin
      valid_nxt      = 1'b1;
      item_nxt.pixel = in_pixel_data;
      item_nxt.col   = col_r;
      item_nxt.row   = row_r;
      item_nxt.last  = img_end;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> hdl/tts_back.sv
// tiled address, byte reversal and the result register
`default_nettype none

module tts_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tts_pkg::cfg_t               cfg,
  input  wire logic                        item_valid,
  output      logic                        item_ready,
  input  wire tts_pkg::item_t              item,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [tts_pkg::ADDR_W-1:0]  out_dest_byte_addr,
  output      logic [tts_pkg::PIX_W-1:0]   out_texel_data,
  output      logic [tts_pkg::BCNT_W-1:0]  out_byte_count,
  output      logic                        out_last_pixel
);
  import tts_pkg::*;

  logic                valid_r;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [PIX_W-1:0]    data_r, data_nxt;
  logic [BCNT_W-1:0]   bcnt_r;
  logic                last_r;
  logic [TILE_W-1:0]   tile;
  logic [MORTON_W-1:0] morton;
  logic [ADDR_W-1:0]   texel;
  logic                load;

  assign item_ready = !valid_r || out_ready;
  assign load       = item_valid && item_ready;

  // tiles per row is a power of two, so the row of tiles is a shift
  assign tile = (TILE_W'(item.row >> TILE_LOG) << cfg.tile_shift)
              + TILE_W'(item.col >> TILE_LOG);
  assign morton = {item.row[2], item.col[2], item.row[1], item.col[1],
                   item.row[0], item.col[0]};
  assign texel = ADDR_W'({tile, {MORTON_W{1'b0}}}) + ADDR_W'(morton);

  always_comb begin
    unique case (cfg.bpp)
      BPP_RGB: begin
        addr_nxt = texel + (texel << 1);
        data_nxt = {8'h00, item.pixel[7:0], item.pixel[15:8], item.pixel[23:16]};
      end
      BPP_ALPHA: begin
        addr_nxt = texel;
        data_nxt = {24'h000000, item.pixel[7:0]};
      end
      default: begin
        addr_nxt = texel << 2;
        data_nxt = {item.pixel[7:0], item.pixel[15:8], item.pixel[23:16],
                    item.pixel[31:24]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (item_ready) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      bcnt_r <= cfg.bpp;
      last_r <= item.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_dest_byte_addr = addr_r;
  assign out_texel_data     = data_r;
  assign out_byte_count     = bcnt_r;
  assign out_last_pixel     = last_r;

endmodule

`default_nettype wire

>>> hdl/tts_checker.sv
// port-level checks for the tiled texture swizzle, bound to the top level
`default_nettype none

module tts_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tts_pkg::ADDR_W-1:0]  out_dest_byte_addr,
  input wire logic [tts_pkg::PIX_W-1:0]   out_texel_data,
  input wire logic [tts_pkg::BCNT_W-1:0]  out_byte_count,
  input wire logic                        out_last_pixel
);
  import tts_pkg::*;

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_byte_addr)
      && $stable(out_texel_data) && $stable(out_byte_count) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  // bytes above the byte count are zero
  a_data_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == BPP_RGBA)
      || (out_byte_count == BPP_RGB && out_texel_data[31:24] == 8'h00)
      || (out_byte_count == BPP_ALPHA && out_texel_data[31:8] == 24'h000000))
    else $error("bad byte count or padding");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind tiled_texture_swizzle tts_checker u_tts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_dest_byte_addr (out_dest_byte_addr),
  .out_texel_data     (out_texel_data),
  .out_byte_count     (out_byte_count),
  .out_last_pixel     (out_last_pixel)
);

`default_nettype wire
